@@ rtl/jbc_pkg.sv @@
// Package for the Java branch and compare unit.
// Holds the action codes, compare constants and the result struct; no dependencies.
package jbc_pkg;
  typedef enum logic [4:0] {
    ACT_IFEQ = 5'd0, ACT_IFNE = 5'd1, ACT_IFLT = 5'd2, ACT_IFGE = 5'd3,
    ACT_IFGT = 5'd4, ACT_IFLE = 5'd5,
    ACT_ICMPEQ = 5'd6, ACT_ICMPNE = 5'd7, ACT_ICMPLT = 5'd8, ACT_ICMPGE = 5'd9,
    ACT_ICMPGT = 5'd10, ACT_ICMPLE = 5'd11,
    ACT_GOTO = 5'd12, ACT_GOTO_W = 5'd13, ACT_JSR = 5'd14, ACT_JSR_W = 5'd15,
    ACT_RET = 5'd16, ACT_LCMP = 5'd17, ACT_FCMPL = 5'd18, ACT_FCMPG = 5'd19,
    ACT_DCMPL = 5'd20, ACT_DCMPG = 5'd21
  } action_t;

  localparam logic [31:0] CMP_MINUS_ONE = 32'hFFFF_FFFF;
  localparam logic [63:0] DBL_INF = 64'h7FF0_0000_0000_0000;
  localparam logic [31:0] FLT_INF = 32'h7F80_0000;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        branch_taken;
    logic        push_valid;
    logic [31:0] push_word;
    logic        target_fault;
  } result_t;
endpackage

@@ rtl/jbc_resolve.sv @@
// Combinational resolution of one control or compare instruction.
// Depends on jbc_pkg for action codes and the result struct.
module jbc_resolve #(
  parameter int CODE_ADDR_WIDTH = 16
) (
  input  logic [4:0]         action,
  input  logic [15:0]        instr_pc,
  input  logic signed [31:0] branch_offset,
  input  logic [63:0]        operand_a,
  input  logic [63:0]        operand_b,
  input  logic [15:0]        return_local,
  output jbc_pkg::result_t   result
);
  localparam logic signed [34:0] LIMIT = 35'sd1 <<< CODE_ADDR_WIDTH;

  function automatic logic [1:0] ieee_cmp(input logic [63:0] a, input logic [63:0] b,
                                          input logic dbl);
    logic [63:0] ma, mb, ka, kb, sgn, inf;
    logic [1:0]  r;
    begin
      sgn = dbl ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
      inf = dbl ? jbc_pkg::DBL_INF : {32'd0, jbc_pkg::FLT_INF};
      if (!dbl) begin
        a = {32'd0, a[31:0]};
        b = {32'd0, b[31:0]};
      end
      ma = a & ~sgn;
      mb = b & ~sgn;
      ka = ((a & sgn) != 0) ? ~a : (a | sgn);
      kb = ((b & sgn) != 0) ? ~b : (b | sgn);
      if (!dbl) begin
        ka = {32'd0, ka[31:0]};
        kb = {32'd0, kb[31:0]};
      end
      if (ma > inf || mb > inf) r = 2'd2;
      else if (ma == 0 && mb == 0) r = 2'd0;
      else if (ka > kb) r = 2'd1;
      else if (ka == kb) r = 2'd0;
      else r = 2'd3;
      ieee_cmp = r;
    end
  endfunction

  function automatic logic int_test(input logic [2:0] sel, input logic signed [31:0] a,
                                    input logic signed [31:0] b);
    case (sel)
      3'd0: int_test = (a == b);
      3'd1: int_test = (a != b);
      3'd2: int_test = (a < b);
      3'd3: int_test = (a >= b);
      3'd4: int_test = (a > b);
      default: int_test = (a <= b);
    endcase
  endfunction

  always_comb begin
    logic signed [34:0] pc, tgt, nxt, ret;
    logic taken, push, fault;
    logic [31:0] word;
    logic [1:0] r;
    pc = $signed({19'd0, instr_pc});
    tgt = pc + 35'(branch_offset);
    nxt = pc + 35'sd1;
    taken = 1'b0;
    push = 1'b0;
    word = 32'd0;
    ret = 35'sd0;
    r = 2'd0;
    case (action)
      jbc_pkg::ACT_IFEQ, jbc_pkg::ACT_IFNE, jbc_pkg::ACT_IFLT, jbc_pkg::ACT_IFGE,
      jbc_pkg::ACT_IFGT, jbc_pkg::ACT_IFLE: begin
        taken = int_test(action[2:0], operand_b[31:0], 32'sd0);
        nxt = taken ? tgt : pc + 35'sd3;
      end
      jbc_pkg::ACT_ICMPEQ, jbc_pkg::ACT_ICMPNE, jbc_pkg::ACT_ICMPLT, jbc_pkg::ACT_ICMPGE,
      jbc_pkg::ACT_ICMPGT, jbc_pkg::ACT_ICMPLE: begin
        taken = int_test(3'(action - 5'd6), operand_a[31:0], operand_b[31:0]);
        nxt = taken ? tgt : pc + 35'sd3;
      end
      jbc_pkg::ACT_GOTO, jbc_pkg::ACT_GOTO_W: begin
        taken = 1'b1;
        nxt = tgt;
      end
      jbc_pkg::ACT_JSR, jbc_pkg::ACT_JSR_W: begin
        ret = pc + ((action == jbc_pkg::ACT_JSR) ? 35'sd3 : 35'sd5);
        taken = 1'b1;
        push = 1'b1;
        word = ret[31:0];
        nxt = (ret >= LIMIT) ? -35'sd1 : tgt;
      end
      jbc_pkg::ACT_RET: begin
        taken = 1'b1;
        nxt = $signed({19'd0, return_local});
      end
      jbc_pkg::ACT_LCMP: begin
        push = 1'b1;
        if ($signed(operand_a) > $signed(operand_b)) word = 32'd1;
        else if (operand_a == operand_b) word = 32'd0;
        else word = jbc_pkg::CMP_MINUS_ONE;
      end
      jbc_pkg::ACT_FCMPL, jbc_pkg::ACT_FCMPG, jbc_pkg::ACT_DCMPL, jbc_pkg::ACT_DCMPG: begin
        r = ieee_cmp(operand_a, operand_b, action >= jbc_pkg::ACT_DCMPL);
        if (r == 2'd2)
          r = (action == jbc_pkg::ACT_FCMPG || action == jbc_pkg::ACT_DCMPG) ? 2'd1 : 2'd3;
        push = 1'b1;
        word = (r == 2'd1) ? 32'd1 : ((r == 2'd0) ? 32'd0 : jbc_pkg::CMP_MINUS_ONE);
      end
      default: ;
    endcase
    fault = (nxt < 0) || (nxt >= LIMIT) || (pc >= LIMIT);
    if (fault) begin
      nxt = pc;
      taken = 1'b0;
      push = 1'b0;
      word = 32'd0;
    end
    result.next_pc = nxt[15:0];
    result.branch_taken = taken;
    result.push_valid = push;
    result.push_word = word;
    result.target_fault = fault;
  end
endmodule

@@ rtl/jvm_branch_compare_unit.sv @@
// Top level of the Java branch and compare unit: input register, resolver, result register.
// Depends on jbc_pkg and jbc_resolve.
//
// Each transfer in is registered, resolved by one pass of combinational logic and held in a
// result register; one item is taken every cycle unless the output stalls, the input
// register refilling whenever the result register is free or draining in the same cycle.
module jvm_branch_compare_unit #(
  parameter int CODE_ADDR_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         action,
  input  logic [15:0]        instr_pc,
  input  logic signed [31:0] branch_offset,
  input  logic [63:0]        operand_a,
  input  logic [63:0]        operand_b,
  input  logic [15:0]        return_local,
  input  logic               wide_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        next_pc,
  output logic               branch_taken,
  output logic               push_valid,
  output logic [31:0]        push_word,
  output logic               target_fault
);
  logic s1_valid;
  logic [4:0] s1_action;
  logic [15:0] s1_pc, s1_rloc;
  logic signed [31:0] s1_off;
  logic [63:0] s1_a, s1_b;
  logic s1_wide;
  jbc_pkg::result_t res, res_q;
  logic out_free, s1_ready;

  assign out_free = !out_valid || out_ready;
  assign s1_ready = !s1_valid || out_free;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (out_free) out_valid <= s1_valid;
    end
    if (in_valid && s1_ready) begin
      s1_action <= action;
      s1_pc <= instr_pc;
      s1_off <= branch_offset;
      s1_a <= operand_a;
      s1_b <= operand_b;
      s1_rloc <= return_local;
      s1_wide <= wide_index;
    end
    if (out_free && s1_valid) res_q <= res;
  end

  jbc_resolve #(.CODE_ADDR_WIDTH(CODE_ADDR_WIDTH)) u_resolve (
    .action(s1_action), .instr_pc(s1_pc), .branch_offset(s1_off),
    .operand_a(s1_a), .operand_b(s1_b), .return_local(s1_rloc), .result(res)
  );

  assign next_pc = res_q.next_pc;
  assign branch_taken = res_q.branch_taken;
  assign push_valid = res_q.push_valid;
  assign push_word = res_q.push_word;
  assign target_fault = res_q.target_fault;

  a_fault_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && target_fault |-> !branch_taken && !push_valid && push_word == 32'd0)
    else $error("fault result carries a branch or push");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_q))
    else $error("stalled result changed");
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ready |=> s1_valid && $stable(s1_pc) && $stable(s1_wide))
    else $error("input register lost an item");
endmodule
